/* rtl/slk_pkg.sv */
// Shared types, codes and helpers for the peer session link keeper.
// No dependencies; imported by every module of the block.
package slk_pkg;

  // Width of the millisecond time base; elapsed times wrap at this width.
  localparam int unsigned TimeBits = 32;

  typedef logic [TimeBits-1:0] time_t;

  typedef enum logic [1:0] {
    OP_PACKET = 2'd0,
    OP_TICK   = 2'd1,
    OP_LOCAL  = 2'd2
  } op_e;

  typedef enum logic [1:0] {
    PKT_HELLO  = 2'd0,
    PKT_ACCEPT = 2'd1,
    PKT_INPUT  = 2'd2
  } pkt_e;

  typedef enum logic [1:0] {
    SEND_NONE   = 2'd0,
    SEND_HELLO  = 2'd1,
    SEND_ACCEPT = 2'd2,
    SEND_INPUT  = 2'd3
  } send_e;

  typedef enum logic [2:0] {
    CFG_ROLE      = 3'd0,
    CFG_SRV_ADDR  = 3'd1,
    CFG_SRV_PORT  = 3'd2,
    CFG_INIT_SESS = 3'd3,
    CFG_LINK_TO   = 3'd4,
    CFG_HELLO_IV  = 3'd5,
    CFG_RELEASE   = 3'd6
  } cfg_idx_e;

  localparam int unsigned CfgIdxBits = 3;

  // Configuration as seen by the engine, plus a one-cycle session reload strobe
  typedef struct packed {
    logic        role_is_client;
    logic [31:0] server_addr;
    logic [15:0] server_port;
    logic [31:0] initial_session_id;
    logic [15:0] link_timeout_ticks;
    logic [15:0] hello_interval_ticks;
    logic [15:0] peer_release_ticks;
    logic        session_reload;
  } cfg_t;

  typedef struct packed {
    logic [1:0]  operation;
    logic [1:0]  packet_kind;
    logic [31:0] source_addr;
    logic [15:0] source_port;
    logic [31:0] packet_session;
    logic [31:0] packet_sequence;
    logic [15:0] pad_buttons;
    logic [63:0] pad_axes;
    logic [31:0] fresh_session_id;
  } item_t;

  typedef struct packed {
    logic [1:0]  send_kind;
    logic [31:0] dest_addr;
    logic [15:0] dest_port;
    logic [31:0] send_sequence;
    logic [31:0] send_session;
    logic [15:0] send_buttons;
    logic [63:0] send_axes;
    logic [15:0] remote_buttons;
    logic [63:0] remote_axes;
    logic        remote_present;
    logic        link_up;
    logic        ever_linked;
  } result_t;

  // Session id after reset or reload: zero for a client, never zero for a host
  function automatic logic [31:0] start_session(logic role, logic [31:0] init_id);
    logic [31:0] sess;
    if (role) begin
      sess = '0;
    end else if (init_id == '0) begin
      sess = 32'd1;
    end else begin
      sess = init_id;
    end
    return sess;
  endfunction

endpackage

/* rtl/slk_cfg_regs.sv */
// Configuration register file for the link keeper.
// Depends on slk_pkg (cfg_t, register index codes).
module slk_cfg_regs (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             wr_en_i,
  input  logic [slk_pkg::CfgIdxBits-1:0]   wr_index_i,
  input  logic [31:0]                      wr_data_i,
  output slk_pkg::cfg_t                    cfg_o
);
  import slk_pkg::*;

  cfg_t cfg_q, cfg_d;

  // Register decode; role or initial id writes trigger a session reload
  always_comb begin
    cfg_d = cfg_q;
    cfg_d.session_reload = 1'b0;
    if (wr_en_i) begin
      unique case (wr_index_i)
        CFG_ROLE: begin
          cfg_d.role_is_client = wr_data_i[0];
          cfg_d.session_reload = 1'b1;
        end
        CFG_SRV_ADDR:  cfg_d.server_addr = wr_data_i;
        CFG_SRV_PORT:  cfg_d.server_port = wr_data_i[15:0];
        CFG_INIT_SESS: begin
          cfg_d.initial_session_id = wr_data_i;
          cfg_d.session_reload     = 1'b1;
        end
        CFG_LINK_TO:   cfg_d.link_timeout_ticks   = wr_data_i[15:0];
        CFG_HELLO_IV:  cfg_d.hello_interval_ticks = wr_data_i[15:0];
        CFG_RELEASE:   cfg_d.peer_release_ticks   = wr_data_i[15:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.role_is_client       <= 1'b0;
      cfg_q.server_addr          <= '0;
      cfg_q.server_port          <= '0;
      cfg_q.initial_session_id   <= 32'd1;
      cfg_q.link_timeout_ticks   <= 16'd1500;
      cfg_q.hello_interval_ticks <= 16'd400;
      cfg_q.peer_release_ticks   <= 16'd5000;
      cfg_q.session_reload       <= 1'b0;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

/* rtl/slk_engine.sv */
// Link state registers and the per-item update logic (one item per cycle while step_i is high).
// Depends on slk_pkg (item_t, result_t, cfg_t, codes, start_session).
module slk_engine (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  slk_pkg::cfg_t    cfg_i,
  input  logic             step_i,
  input  slk_pkg::item_t   item_i,
  output slk_pkg::result_t result_o
);
  import slk_pkg::*;

  time_t       now_q, now_d;
  logic [31:0] seq_q, seq_d;
  logic [31:0] sess_q, sess_d;
  logic [31:0] rseq_q, rseq_d;
  logic        rseq_vld_q, rseq_vld_d;
  logic        locked_q, locked_d;
  logic [31:0] peer_addr_q, peer_addr_d;
  logic [15:0] peer_port_q, peer_port_d;
  logic [15:0] held_btn_q, held_btn_d;
  logic [63:0] held_axes_q, held_axes_d;
  logic        conn_q, conn_d;
  logic        ever_q, ever_d;
  time_t       rx_time_q, rx_time_d;
  time_t       lost_time_q, lost_time_d;
  logic        hello_sent_q, hello_sent_d;
  time_t       hello_time_q, hello_time_d;

  result_t     res;
  logic [31:0] sess_cur;
  logic        same_peer;
  logic        src_is_srv;
  logic [31:0] seq_diff;
  logic        take_ok;
  logic        do_take;
  time_t       now_inc;
  logic        rx_passed;
  logic        hello_passed;
  logic        lost_passed;

  // Session in effect for this item: a pending reload takes precedence
  assign sess_cur = cfg_i.session_reload ?
                    start_session(cfg_i.role_is_client, cfg_i.initial_session_id) : sess_q;

  // Wrapping compares, all against the incremented time of a tick
  assign now_inc      = now_q + time_t'(1);
  assign rx_passed    = (now_inc - rx_time_q) > time_t'(cfg_i.link_timeout_ticks);
  assign hello_passed = (now_inc - hello_time_q) > time_t'(cfg_i.hello_interval_ticks);
  assign lost_passed  = (now_inc - lost_time_q) > time_t'(cfg_i.peer_release_ticks);

  assign same_peer  = locked_q && peer_addr_q == item_i.source_addr &&
                      peer_port_q == item_i.source_port;
  assign src_is_srv = item_i.source_addr == cfg_i.server_addr &&
                      item_i.source_port == cfg_i.server_port;
  // Remote input is kept only if its sequence is newer (serial-number compare)
  assign seq_diff   = item_i.packet_sequence - rseq_q;
  assign take_ok    = !rseq_vld_q || (seq_diff != '0 && !seq_diff[31]);
  assign do_take    = item_i.packet_kind == PKT_INPUT &&
                      item_i.packet_session == sess_cur && take_ok &&
                      (cfg_i.role_is_client ? src_is_srv : same_peer);

  // Next state and outgoing packet
  always_comb begin
    now_d        = now_q;
    seq_d        = seq_q;
    sess_d       = sess_cur;
    rseq_d       = rseq_q;
    rseq_vld_d   = rseq_vld_q;
    locked_d     = locked_q;
    peer_addr_d  = peer_addr_q;
    peer_port_d  = peer_port_q;
    held_btn_d   = held_btn_q;
    held_axes_d  = held_axes_q;
    conn_d       = conn_q;
    ever_d       = ever_q;
    rx_time_d    = rx_time_q;
    lost_time_d  = lost_time_q;
    hello_sent_d = hello_sent_q;
    hello_time_d = hello_time_q;
    res          = '0;

    case (item_i.operation)
      OP_PACKET: begin
        if (!cfg_i.role_is_client && item_i.packet_kind == PKT_HELLO) begin
          // host: lock onto the first caller, answer Accept to the locked one
          if (!locked_q || same_peer) begin
            if (!locked_q) begin
              locked_d    = 1'b1;
              peer_addr_d = item_i.source_addr;
              peer_port_d = item_i.source_port;
              lost_time_d = now_q;
            end
            res.send_kind     = SEND_ACCEPT;
            res.dest_addr     = item_i.source_addr;
            res.dest_port     = item_i.source_port;
            res.send_sequence = seq_q;
            res.send_session  = sess_cur;
            seq_d             = seq_q + 32'd1;
          end
        end else if (cfg_i.role_is_client && src_is_srv &&
                     item_i.packet_kind == PKT_ACCEPT && item_i.packet_session != '0) begin
          // client: adopt the host session
          if (sess_cur != item_i.packet_session) begin
            sess_d     = item_i.packet_session;
            rseq_vld_d = 1'b0;
          end
          rx_time_d   = now_q;
          lost_time_d = now_q;
          ever_d      = 1'b1;
          conn_d      = 1'b1;
        end else if (do_take) begin
          held_btn_d  = item_i.pad_buttons;
          held_axes_d = item_i.pad_axes;
          rseq_d      = item_i.packet_sequence;
          rseq_vld_d  = 1'b1;
          rx_time_d   = now_q;
          lost_time_d = now_q;
          ever_d      = 1'b1;
          conn_d      = 1'b1;
        end
      end
      OP_TICK: begin
        now_d = now_inc;
        // client hello retransmit while unlinked
        if (cfg_i.role_is_client && (!conn_q || rx_passed) &&
            (!hello_sent_q || hello_passed)) begin
          res.send_kind     = SEND_HELLO;
          res.dest_addr     = cfg_i.server_addr;
          res.dest_port     = cfg_i.server_port;
          res.send_sequence = seq_q;
          seq_d             = seq_q + 32'd1;
          hello_time_d      = now_inc;
          hello_sent_d      = 1'b1;
        end
        // receive timeout drops the link
        if (conn_q && rx_passed) begin
          conn_d      = 1'b0;
          lost_time_d = now_inc;
          held_btn_d  = '0;
          held_axes_d = '0;
        end
        // host frees a peer lost for long enough (a just-dropped link has zero elapsed)
        if (!cfg_i.role_is_client && !conn_q && locked_q && lost_passed) begin
          locked_d   = 1'b0;
          sess_d     = start_session(1'b0, item_i.fresh_session_id);
          rseq_vld_d = 1'b0;
        end
      end
      OP_LOCAL: begin
        if (conn_q && (cfg_i.role_is_client || locked_q)) begin
          res.send_kind     = SEND_INPUT;
          res.dest_addr     = cfg_i.role_is_client ? cfg_i.server_addr : peer_addr_q;
          res.dest_port     = cfg_i.role_is_client ? cfg_i.server_port : peer_port_q;
          res.send_sequence = seq_q;
          res.send_session  = sess_cur;
          res.send_buttons  = item_i.pad_buttons;
          res.send_axes     = item_i.pad_axes;
          seq_d             = seq_q + 32'd1;
        end
      end
      default: ;
    endcase

    // link status reflects the state after this item
    res.remote_buttons = conn_d ? held_btn_d : '0;
    res.remote_axes    = conn_d ? held_axes_d : '0;
    res.remote_present = conn_d;
    res.link_up        = conn_d;
    res.ever_linked    = ever_d;
  end

  assign result_o = res;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      now_q        <= '0;
      seq_q        <= 32'd1;
      sess_q       <= 32'd1;
      rseq_q       <= '0;
      rseq_vld_q   <= 1'b0;
      locked_q     <= 1'b0;
      peer_addr_q  <= '0;
      peer_port_q  <= '0;
      held_btn_q   <= '0;
      held_axes_q  <= '0;
      conn_q       <= 1'b0;
      ever_q       <= 1'b0;
      rx_time_q    <= '0;
      lost_time_q  <= '0;
      hello_sent_q <= 1'b0;
      hello_time_q <= '0;
    end else if (step_i) begin
      now_q        <= now_d;
      seq_q        <= seq_d;
      sess_q       <= sess_d;
      rseq_q       <= rseq_d;
      rseq_vld_q   <= rseq_vld_d;
      locked_q     <= locked_d;
      peer_addr_q  <= peer_addr_d;
      peer_port_q  <= peer_port_d;
      held_btn_q   <= held_btn_d;
      held_axes_q  <= held_axes_d;
      conn_q       <= conn_d;
      ever_q       <= ever_d;
      rx_time_q    <= rx_time_d;
      lost_time_q  <= lost_time_d;
      hello_sent_q <= hello_sent_d;
      hello_time_q <= hello_time_d;
    end else if (cfg_i.session_reload) begin
      sess_q <= sess_cur;
    end
  end

endmodule

/* rtl/peer_session_link_keeper.sv */
// Peer session link keeper: input register, link engine, result register.
// Two register stages: input register, then result register once the result slot is free.
// Throughput: one item per cycle while the result register is empty or being taken.
// Ready drops only while the result register is full and not being taken.
// Async active-low reset clears link state and loads the reset configuration.
// Depends on slk_pkg, slk_cfg_regs and slk_engine.
module peer_session_link_keeper (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  // configuration write channel
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [slk_pkg::CfgIdxBits-1:0] cfg_index_i,
  input  logic [31:0]                    cfg_data_i,
  // input item channel
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  logic [1:0]                     operation_i,
  input  logic [1:0]                     packet_kind_i,
  input  logic [31:0]                    source_addr_i,
  input  logic [15:0]                    source_port_i,
  input  logic [31:0]                    packet_session_i,
  input  logic [31:0]                    packet_sequence_i,
  input  logic [15:0]                    pad_buttons_i,
  input  logic [63:0]                    pad_axes_i,
  input  logic [31:0]                    fresh_session_id_i,
  // result item channel
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output logic [1:0]                     send_kind_o,
  output logic [31:0]                    dest_addr_o,
  output logic [15:0]                    dest_port_o,
  output logic [31:0]                    send_sequence_o,
  output logic [31:0]                    send_session_o,
  output logic [15:0]                    send_buttons_o,
  output logic [63:0]                    send_axes_o,
  output logic [15:0]                    remote_buttons_o,
  output logic [63:0]                    remote_axes_o,
  output logic                           remote_present_o,
  output logic                           link_up_o,
  output logic                           ever_linked_o
);
  import slk_pkg::*;

  cfg_t    cfg;
  item_t   item_q;
  logic    in_vld_q;
  result_t eng_res;
  result_t res_q;
  logic    out_vld_q;
  logic    advance;
  logic    in_take;

  assign cfg_ready_o = 1'b1;

  slk_cfg_regs u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .wr_en_i    (cfg_valid_i),
    .wr_index_i (cfg_index_i),
    .wr_data_i  (cfg_data_i),
    .cfg_o      (cfg)
  );

  // Pipeline control: the held item moves on when the result slot frees up
  assign advance    = in_vld_q && (!out_vld_q || out_ready_i);
  assign in_ready_o = !in_vld_q || advance;
  assign in_take    = in_valid_i && in_ready_o;

  // Input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (in_take) begin
      in_vld_q <= 1'b1;
    end else if (advance) begin
      in_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      item_q.operation        <= operation_i;
      item_q.packet_kind      <= packet_kind_i;
      item_q.source_addr      <= source_addr_i;
      item_q.source_port      <= source_port_i;
      item_q.packet_session   <= packet_session_i;
      item_q.packet_sequence  <= packet_sequence_i;
      item_q.pad_buttons      <= pad_buttons_i;
      item_q.pad_axes         <= pad_axes_i;
      item_q.fresh_session_id <= fresh_session_id_i;
    end
  end

  slk_engine u_engine (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .cfg_i    (cfg),
    .step_i   (advance),
    .item_i   (item_q),
    .result_o (eng_res)
  );

  // Result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (advance) begin
      out_vld_q <= 1'b1;
    end else if (out_ready_i) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      res_q <= eng_res;
    end
  end

  assign out_valid_o      = out_vld_q;
  assign send_kind_o      = res_q.send_kind;
  assign dest_addr_o      = res_q.dest_addr;
  assign dest_port_o      = res_q.dest_port;
  assign send_sequence_o  = res_q.send_sequence;
  assign send_session_o   = res_q.send_session;
  assign send_buttons_o   = res_q.send_buttons;
  assign send_axes_o      = res_q.send_axes;
  assign remote_buttons_o = res_q.remote_buttons;
  assign remote_axes_o    = res_q.remote_axes;
  assign remote_present_o = res_q.remote_present;
  assign link_up_o        = res_q.link_up;
  assign ever_linked_o    = res_q.ever_linked;

  // A result with the link down carries a blank remote pad
  a_blank_remote: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_vld_q && !res_q.link_up) |-> (res_q.remote_buttons == '0 &&
                                       res_q.remote_axes == '0))
    else $error("remote pad not blanked while link is down");

  // A live link implies the sticky linked flag
  a_ever_linked: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_vld_q && res_q.link_up) |-> res_q.ever_linked)
    else $error("link up without ever_linked");

  // Nothing sent means the send sequence and destination address are zero
  a_idle_send: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_vld_q && res_q.send_kind == SEND_NONE) |-> (res_q.send_sequence == '0 &&
                                                     res_q.dest_addr == '0))
    else $error("send fields set with no packet to send");

  // An item moved to the engine shows up as a valid result next cycle
  a_advance_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance |=> out_vld_q)
    else $error("result lost after engine step");

endmodule

/* tb/sv/tb.sv */
// Testbench for peer_session_link_keeper: directed and random items, each result checked
// against an in-bench model of the link state. Depends on slk_pkg and the block's RTL.
module tb;
  import slk_pkg::*;

  // codes the block must ignore
  localparam logic [1:0] OP_UNUSED  = 2'd3;
  localparam logic [1:0] PKT_UNUSED = 2'd3;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  logic [CfgIdxBits-1:0] cfg_index_i = '0;
  logic [31:0] cfg_data_i = '0;
  logic        in_valid_i = 1'b0;
  logic        in_ready_o;
  logic [1:0]  operation_i = '0;
  logic [1:0]  packet_kind_i = '0;
  logic [31:0] source_addr_i = '0;
  logic [15:0] source_port_i = '0;
  logic [31:0] packet_session_i = '0;
  logic [31:0] packet_sequence_i = '0;
  logic [15:0] pad_buttons_i = '0;
  logic [63:0] pad_axes_i = '0;
  logic [31:0] fresh_session_id_i = '0;
  logic        out_valid_o;
  logic        out_ready_i = 1'b1;
  logic [1:0]  send_kind_o;
  logic [31:0] dest_addr_o;
  logic [15:0] dest_port_o;
  logic [31:0] send_sequence_o;
  logic [31:0] send_session_o;
  logic [15:0] send_buttons_o;
  logic [63:0] send_axes_o;
  logic [15:0] remote_buttons_o;
  logic [63:0] remote_axes_o;
  logic        remote_present_o;
  logic        link_up_o;
  logic        ever_linked_o;

  peer_session_link_keeper uut (.*);

  // clock, period 10
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // model configuration
  logic        client_role;
  logic [31:0] host_addr;
  logic [15:0] host_port;
  logic [31:0] first_session;
  logic [15:0] link_limit;
  logic [15:0] hello_gap;
  logic [15:0] release_limit;

  // model link state
  time_t       clock_ms;
  logic [31:0] tx_seq;
  logic [31:0] cur_session;
  logic [31:0] rx_seq;
  logic        rx_seq_ok;
  logic        locked;
  logic [31:0] peer_ip;
  logic [15:0] peer_udp;
  logic [15:0] pad_btn;
  logic [63:0] pad_ax;
  logic        linked;
  logic        linked_once;
  time_t       rx_time;
  time_t       lost_time;
  logic        hello_out;
  time_t       hello_time;

  result_t     expected_results[$];
  result_t     want;

  // stimulus context
  int unsigned idle_pct = 0;
  int unsigned stall_pct = 0;
  logic [31:0] main_ip;
  logic [15:0] main_udp;
  logic [31:0] peer_seq;
  logic [31:0] srv_session;

  int unsigned n_errors = 0, n_items = 0, n_checked = 0;
  int unsigned n_hello = 0, n_accept = 0, n_input = 0;
  int unsigned n_kept = 0, n_drops = 0, n_releases = 0;

  // ---------------------------------------------------------------- model

  function automatic void reload_session();
    cur_session = client_role ? 32'd0 : (first_session == '0 ? 32'd1 : first_session);
  endfunction

  function automatic void reset_predictor();
    client_role   = 1'b0;
    host_addr     = '0;
    host_port     = '0;
    first_session = 32'd1;
    link_limit    = 16'd1500;
    hello_gap     = 16'd400;
    release_limit = 16'd5000;
    clock_ms      = '0;
    tx_seq        = 32'd1;
    reload_session();
    rx_seq        = '0;
    rx_seq_ok     = 1'b0;
    locked        = 1'b0;
    peer_ip       = '0;
    peer_udp      = '0;
    pad_btn       = '0;
    pad_ax        = '0;
    linked        = 1'b0;
    linked_once   = 1'b0;
    rx_time       = '0;
    lost_time     = '0;
    hello_out     = 1'b0;
    hello_time    = '0;
  endfunction

  function automatic void apply_reg(cfg_idx_e idx, logic [31:0] val);
    case (idx)
      CFG_ROLE: begin
        client_role = val[0];
        reload_session();
      end
      CFG_SRV_ADDR:  host_addr = val;
      CFG_SRV_PORT:  host_port = val[15:0];
      CFG_INIT_SESS: begin
        first_session = val;
        reload_session();
      end
      CFG_LINK_TO:   link_limit = val[15:0];
      CFG_HELLO_IV:  hello_gap = val[15:0];
      CFG_RELEASE:   release_limit = val[15:0];
      default: ;
    endcase
  endfunction

  // elapsed time strictly beyond the limit, wrapping at the time width
  function automatic logic timed_out(time_t since, logic [15:0] limit);
    time_t gone;
    gone = clock_ms - since;
    return gone > time_t'(limit);
  endfunction

  function automatic logic seq_is_newer(logic [31:0] a, logic [31:0] b);
    logic [31:0] d;
    d = a - b;
    return d != '0 && d < 32'h8000_0000;
  endfunction

  function automatic result_t outgoing(send_e kind, logic [31:0] addr, logic [15:0] port,
                                       logic [31:0] sess, logic [15:0] btn, logic [63:0] ax);
    result_t r;
    r = '0;
    r.send_kind     = kind;
    r.dest_addr     = addr;
    r.dest_port     = port;
    r.send_sequence = tx_seq;
    r.send_session  = sess;
    r.send_buttons  = btn;
    r.send_axes     = ax;
    tx_seq = tx_seq + 32'd1;
    case (kind)
      SEND_HELLO:  n_hello++;
      SEND_ACCEPT: n_accept++;
      SEND_INPUT:  n_input++;
      default: ;
    endcase
    return r;
  endfunction

  // keep a remote pad only when its sequence is newer than the last one kept
  function automatic void keep_remote_pad(logic [31:0] seq, logic [15:0] btn, logic [63:0] ax);
    if (rx_seq_ok && !seq_is_newer(seq, rx_seq)) return;
    pad_btn     = btn;
    pad_ax      = ax;
    rx_seq      = seq;
    rx_seq_ok   = 1'b1;
    rx_time     = clock_ms;
    lost_time   = clock_ms;
    linked_once = 1'b1;
    linked      = 1'b1;
    n_kept++;
  endfunction

  function automatic result_t predict_result(item_t it);
    result_t r;
    logic    same_peer;
    r = '0;
    case (it.operation)
      OP_PACKET: begin
        if (!client_role) begin
          same_peer = locked && peer_ip == it.source_addr && peer_udp == it.source_port;
          if (it.packet_kind == PKT_HELLO) begin
            if (!locked || same_peer) begin
              if (!locked) begin
                locked    = 1'b1;
                peer_ip   = it.source_addr;
                peer_udp  = it.source_port;
                lost_time = clock_ms;
              end
              r = outgoing(SEND_ACCEPT, it.source_addr, it.source_port, cur_session, '0, '0);
            end
          end else if (same_peer && it.packet_kind == PKT_INPUT &&
                       it.packet_session == cur_session) begin
            keep_remote_pad(it.packet_sequence, it.pad_buttons, it.pad_axes);
          end
        end else if (it.source_addr == host_addr && it.source_port == host_port) begin
          if (it.packet_kind == PKT_ACCEPT && it.packet_session != '0) begin
            if (cur_session != it.packet_session) begin
              cur_session = it.packet_session;
              rx_seq_ok   = 1'b0;
            end
            rx_time     = clock_ms;
            lost_time   = clock_ms;
            linked_once = 1'b1;
            linked      = 1'b1;
          end else if (it.packet_kind == PKT_INPUT && it.packet_session == cur_session) begin
            keep_remote_pad(it.packet_sequence, it.pad_buttons, it.pad_axes);
          end
        end
      end
      OP_TICK: begin
        clock_ms = clock_ms + 1;
        // client keeps saying hello while unlinked
        if (client_role && (!linked || timed_out(rx_time, link_limit)) &&
            (!hello_out || timed_out(hello_time, hello_gap))) begin
          r = outgoing(SEND_HELLO, host_addr, host_port, '0, '0, '0);
          hello_time = clock_ms;
          hello_out  = 1'b1;
        end
        if (linked && timed_out(rx_time, link_limit)) begin
          linked    = 1'b0;
          lost_time = clock_ms;
          pad_btn   = '0;
          pad_ax    = '0;
          n_drops++;
        end
        // host frees a lost peer and starts a new session
        if (!client_role && !linked && locked && timed_out(lost_time, release_limit)) begin
          locked      = 1'b0;
          cur_session = it.fresh_session_id == '0 ? 32'd1 : it.fresh_session_id;
          rx_seq_ok   = 1'b0;
          n_releases++;
        end
      end
      OP_LOCAL: begin
        if (linked && (client_role || locked)) begin
          r = outgoing(SEND_INPUT, client_role ? host_addr : peer_ip,
                       client_role ? host_port : peer_udp, cur_session,
                       it.pad_buttons, it.pad_axes);
        end
      end
      default: ;
    endcase
    r.remote_buttons = linked ? pad_btn : '0;
    r.remote_axes    = linked ? pad_ax : '0;
    r.remote_present = linked;
    r.link_up        = linked;
    r.ever_linked    = linked_once;
    return r;
  endfunction

  // ---------------------------------------------------------------- checking

  task automatic report_mismatch(input string msg);
    $display("mismatch at %0t: %s", $realtime, msg);
    n_errors++;
  endtask

  task automatic check_field(input string name, input logic [63:0] got, input logic [63:0] exp_v);
    if (got !== exp_v)
      report_mismatch($sformatf("result %0d %s got %0h expected %0h", n_checked, name,
                                got, exp_v));
  endtask

  // compare each accepted result with the oldest expectation
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (expected_results.size() == 0) begin
        report_mismatch("result with nothing expected");
      end else begin
        want = expected_results.pop_front();
        check_field("send_kind", 64'(send_kind_o), 64'(want.send_kind));
        check_field("dest_addr", 64'(dest_addr_o), 64'(want.dest_addr));
        check_field("dest_port", 64'(dest_port_o), 64'(want.dest_port));
        check_field("send_sequence", 64'(send_sequence_o), 64'(want.send_sequence));
        check_field("send_session", 64'(send_session_o), 64'(want.send_session));
        check_field("send_buttons", 64'(send_buttons_o), 64'(want.send_buttons));
        check_field("send_axes", send_axes_o, want.send_axes);
        check_field("remote_buttons", 64'(remote_buttons_o), 64'(want.remote_buttons));
        check_field("remote_axes", remote_axes_o, want.remote_axes);
        check_field("remote_present", 64'(remote_present_o), 64'(want.remote_present));
        check_field("link_up", 64'(link_up_o), 64'(want.link_up));
        check_field("ever_linked", 64'(ever_linked_o), 64'(want.ever_linked));
        n_checked++;
      end
    end
  end

  // receiver backpressure
  always @(negedge clk_i) out_ready_i <= ($urandom_range(99) >= stall_pct);

  // ---------------------------------------------------------------- drivers

  task automatic set_profile(input int unsigned idle, input int unsigned stall);
    idle_pct  = idle;
    stall_pct = stall;
  endtask

  task automatic send_item(input item_t it);
    while (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
      @(negedge clk_i);
      in_valid_i <= 1'b0;
    end
    @(negedge clk_i);
    in_valid_i         <= 1'b1;
    operation_i        <= it.operation;
    packet_kind_i      <= it.packet_kind;
    source_addr_i      <= it.source_addr;
    source_port_i      <= it.source_port;
    packet_session_i   <= it.packet_session;
    packet_sequence_i  <= it.packet_sequence;
    pad_buttons_i      <= it.pad_buttons;
    pad_axes_i         <= it.pad_axes;
    fresh_session_id_i <= it.fresh_session_id;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    expected_results.push_back(predict_result(it));
    n_items++;
  endtask

  // hold the sender until every result is back and the pipeline is empty
  task automatic settle_block();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_reg(input cfg_idx_e idx, input logic [31:0] val);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    apply_reg(idx, val);
  endtask

  task automatic configure(input logic role, input logic [31:0] addr, input logic [15:0] port,
                           input logic [31:0] init_id, input logic [15:0] link_ticks,
                           input logic [15:0] hello_ticks, input logic [15:0] rel_ticks);
    settle_block();
    write_reg(CFG_ROLE, {31'd0, role});
    write_reg(CFG_SRV_ADDR, addr);
    write_reg(CFG_SRV_PORT, {16'd0, port});
    write_reg(CFG_INIT_SESS, init_id);
    write_reg(CFG_LINK_TO, {16'd0, link_ticks});
    write_reg(CFG_HELLO_IV, {16'd0, hello_ticks});
    write_reg(CFG_RELEASE, {16'd0, rel_ticks});
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic send_packet(input logic [1:0] kind, input logic [31:0] addr,
                             input logic [15:0] port, input logic [31:0] sess,
                             input logic [31:0] seq, input logic [15:0] btn,
                             input logic [63:0] ax);
    item_t it;
    it = '0;
    it.operation       = OP_PACKET;
    it.packet_kind     = kind;
    it.source_addr     = addr;
    it.source_port     = port;
    it.packet_session  = sess;
    it.packet_sequence = seq;
    it.pad_buttons     = btn;
    it.pad_axes        = ax;
    send_item(it);
  endtask

  task automatic send_tick(input logic [31:0] fresh);
    item_t it;
    it = '0;
    it.operation        = OP_TICK;
    it.fresh_session_id = fresh;
    send_item(it);
  endtask

  task automatic send_pad_sample(input logic [15:0] btn, input logic [63:0] ax);
    item_t it;
    it = '0;
    it.operation   = OP_LOCAL;
    it.pad_buttons = btn;
    it.pad_axes    = ax;
    send_item(it);
  endtask

  // ---------------------------------------------------------------- random items

  // remote sender's sequence: mostly advancing, sometimes stale, half way or random
  function automatic logic [31:0] next_peer_seq();
    int unsigned r;
    r = $urandom_range(19);
    if (r < 14) begin
      peer_seq = peer_seq + $urandom_range(3, 1);
      return peer_seq;
    end
    if (r < 17) return peer_seq - $urandom_range(2);
    if (r < 18) return peer_seq + 32'h8000_0000;
    return $urandom;
  endfunction

  function automatic item_t random_item();
    item_t       it;
    int unsigned pick;
    int unsigned r;
    it.operation        = OP_TICK;
    it.packet_kind      = 2'($urandom_range(3));
    it.source_addr      = $urandom;
    it.source_port      = 16'($urandom);
    it.packet_session   = $urandom;
    it.packet_sequence  = $urandom;
    it.pad_buttons      = 16'($urandom);
    it.pad_axes         = {$urandom, $urandom};
    it.fresh_session_id = ($urandom_range(99) < 15) ? 32'd0 : $urandom;
    pick = $urandom_range(99);
    if (pick < 35) begin
      it.operation = OP_TICK;
    end else if (pick < 90 && pick >= 77) begin
      it.operation = OP_LOCAL;
    end else if (pick >= 90) begin
      // noise: any code, half of it from the expected endpoint
      it.operation = 2'($urandom_range(3));
      if ($urandom_range(1) == 0) begin
        it.source_addr = client_role ? host_addr : main_ip;
        it.source_port = client_role ? host_port : main_udp;
      end
    end else if (!client_role) begin
      it.operation = OP_PACKET;
      if (pick < 47) begin
        it.packet_kind = PKT_HELLO;
        it.source_addr = main_ip;
        it.source_port = main_udp;
      end else if (pick < 52) begin
        it.packet_kind = PKT_HELLO;
      end else begin
        it.packet_kind     = PKT_INPUT;
        it.source_addr     = main_ip;
        it.source_port     = main_udp;
        it.packet_sequence = next_peer_seq();
        if ($urandom_range(9) != 0) it.packet_session = cur_session;
      end
    end else begin
      it.operation   = OP_PACKET;
      it.source_addr = host_addr;
      it.source_port = host_port;
      if (pick < 45) begin
        it.packet_kind = PKT_ACCEPT;
        r = $urandom_range(19);
        if (r == 0) srv_session = $urandom;
        it.packet_session = (r == 1) ? 32'd0 : srv_session;
      end else begin
        it.packet_kind     = PKT_INPUT;
        it.packet_sequence = next_peer_seq();
        if ($urandom_range(9) != 0) it.packet_session = cur_session;
      end
    end
    return it;
  endfunction

  task automatic run_traffic(input int unsigned count);
    repeat (count) begin
      if ($urandom_range(49) == 0) settle_block();
      send_item(random_item());
    end
  endtask

  // ---------------------------------------------------------------- tests

  // host: locking, filtering by endpoint, session and sequence, timeout and release
  task automatic test_host_lock_and_filter();
    set_profile(0, 0);
    configure(1'b0, 32'h0, 16'h0, 32'h0, 16'd1, 16'd400, 16'd1);
    send_pad_sample(16'hFFFF, '1);
    send_packet(PKT_INPUT, '1, '1, 32'd1, 32'd3, 16'h00FF, 64'h1);
    send_item(item_t'({OP_UNUSED, 194'd0, 32'd0}));
    send_packet(PKT_HELLO, '1, '1, '0, '0, '0, '0);
    send_packet(PKT_HELLO, 32'h0, 16'h0, '0, '0, '0, '0);
    send_packet(PKT_INPUT, '1, '1, 32'd2, 32'd5, 16'hFFFF, '1);
    send_packet(PKT_INPUT, '1, '1, 32'd1, 32'd5, 16'hFFFF, '1);
    send_packet(PKT_INPUT, '1, '1, 32'd1, 32'd5, 16'h5555, 64'h5);
    send_packet(PKT_INPUT, '1, '1, 32'd1, 32'h8000_0005, 16'hAAAA, 64'hA);
    send_packet(PKT_INPUT, '1, '1, 32'd1, 32'h8000_0004, 16'h0, 64'h0);
    send_pad_sample(16'hFFFF, '1);
    send_packet(PKT_UNUSED, '1, '1, 32'd1, 32'h8000_0010, 16'h1, 64'h1);
    send_packet(PKT_HELLO, '1, '1, '0, '0, '0, '0);
    send_tick(32'd9);
    send_tick(32'd9);
    send_tick(32'd9);
    send_tick(32'd0);
  endtask

  // client: hello timer, adopting a session from accept, remote input, link loss
  task automatic test_client_join();
    set_profile(0, 0);
    configure(1'b1, 32'hC0A8_0001, 16'd5000, 32'hFFFF_FFFF, 16'd0, 16'd0, 16'd65535);
    send_tick($urandom);
    send_packet(PKT_ACCEPT, 32'hC0A8_0001, 16'd5000, 32'd0, '0, '0, '0);
    send_packet(PKT_ACCEPT, 32'hC0A8_0002, 16'd5000, 32'd7, '0, '0, '0);
    send_packet(PKT_ACCEPT, 32'hC0A8_0001, 16'd5000, '1, '0, '0, '0);
    send_packet(PKT_HELLO, 32'hC0A8_0001, 16'd5000, '1, '0, '0, '0);
    send_packet(PKT_INPUT, 32'hC0A8_0001, 16'd5000, '1, 32'd0, 16'h8001, 64'hFF00_0000_0000_00FF);
    send_pad_sample(16'h1234, 64'h0123_4567_89AB_CDEF);
    send_tick($urandom);
  endtask

  task automatic test_host_traffic();
    main_ip  = $urandom;
    main_udp = 16'($urandom);
    peer_seq = 32'hFFFF_FFF0;
    set_profile(0, 0);
    configure(1'b0, $urandom, 16'($urandom), 32'hFFFF_FFFF, 16'd3, 16'd2, 16'd5);
    run_traffic(80);
    main_ip  = $urandom;
    peer_seq = $urandom;
    set_profile(56, 0);
    configure(1'b0, $urandom, 16'($urandom), $urandom, 16'd6, 16'd400, 16'd9);
    run_traffic(75);
  endtask

  task automatic test_client_traffic();
    srv_session = $urandom;
    peer_seq    = $urandom;
    set_profile(0, 56);
    configure(1'b1, 32'hFFFF_FFFF, 16'hFFFF, 32'd1, 16'd4, 16'd3, 16'd5000);
    run_traffic(75);
    srv_session = $urandom;
    set_profile(28, 28);
    configure(1'b1, $urandom, 16'($urandom), $urandom, 16'd7, 16'd2, 16'd3);
    run_traffic(75);
  endtask

  // timers at both ends of their range, role switches in between
  task automatic test_timer_extremes();
    main_ip  = $urandom;
    main_udp = 16'($urandom);
    set_profile(28, 28);
    configure(1'b0, $urandom, 16'($urandom), $urandom, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    run_traffic(50);
    srv_session = $urandom;
    set_profile(56, 0);
    configure(1'b1, 32'h0, 16'h0, 32'h0, 16'd0, 16'd0, 16'd0);
    run_traffic(50);
    set_profile(0, 56);
    configure(1'b0, $urandom, 16'($urandom), 32'h0, 16'd0, 16'd0, 16'd0);
    run_traffic(50);
  endtask

  // ---------------------------------------------------------------- sequence

  initial begin
    reset_predictor();
    repeat (10) @(negedge clk_i);
    rst_ni <= 1'b1;
    test_host_lock_and_filter();
    test_client_join();
    test_host_traffic();
    test_client_traffic();
    test_timer_extremes();
    settle_block();
    repeat (8) @(posedge clk_i);
    $display("covered %0d items, %0d results; sent %0d hello, %0d accept, %0d input",
             n_items, n_checked, n_hello, n_accept, n_input);
    $display("remote pads kept %0d, link drops %0d, peer releases %0d, mismatches %0d",
             n_kept, n_drops, n_releases, n_errors);
    if (n_errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  // watchdog
  initial begin
    #2000000;
    $display("TB_ERROR");
    $finish;
  end

endmodule
